@@ rtl/topology_preserving_peel_check_macros.svh @@
// ----------------------------------------------------------------------------
// Peel check assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TOPOLOGY_PRESERVING_PEEL_CHECK_MACROS_SVH
`define TOPOLOGY_PRESERVING_PEEL_CHECK_MACROS_SVH

`ifndef ASSERT_OFF
`define TPPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TPPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TPPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TPPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/tppc_pkg.sv @@
// ----------------------------------------------------------------------------
// Peel check package
// Word types and cube constants shared by the peel check modules.
// ----------------------------------------------------------------------------
package tppc_pkg;

	localparam int CELLS     = 27;
	localparam int CENTRE    = 13;
	localparam int SQUARINGS = 5;   // paths up to 32 steps cover the cube
	localparam int CNT_W     = 4;

	localparam logic [CELLS-1:0] CENTRE_MASK = 27'h0002000;
	localparam logic [7:0]       BACKGROUND  = 8'hFF;

	typedef struct packed {
		logic [7:0]       centre_value;
		logic [CELLS-1:0] neighbour_occupancy;
	} in_word_t;

	typedef struct packed {
		logic             remove_voxel;
		logic [7:0]       new_value;
		logic [CNT_W-1:0] components_before;
	} result_t;

endpackage

@@ rtl/tppc_comp_count.sv @@
// ----------------------------------------------------------------------------
// Peel check component counter
// Counts 6-connected components of a 3x3x3 occupancy mask by boolean
// reachability closure (repeated squaring), then counts component leaders.
// ----------------------------------------------------------------------------
module tppc_comp_count (
	input  logic [tppc_pkg::CELLS-1:0] occ,
	output logic [tppc_pkg::CNT_W-1:0] count
);
	import tppc_pkg::*;

	logic [CELLS-1:0] reach [SQUARINGS+1][CELLS];
	logic [CELLS-1:0] lead;
	logic [4:0]       lead_cnt;

	genvar gi, gj, gk;
	generate
		for (gi = 0; gi < CELLS; gi++) begin : g_row
			for (gj = 0; gj < CELLS; gj++) begin : g_col
				localparam int XI = gi / 9;
				localparam int YI = (gi / 3) % 3;
				localparam int ZI = gi % 3;
				localparam int XJ = gj / 9;
				localparam int YJ = (gj / 3) % 3;
				localparam int ZJ = gj % 3;
				localparam int DX = (XI > XJ) ? XI - XJ : XJ - XI;
				localparam int DY = (YI > YJ) ? YI - YJ : YJ - YI;
				localparam int DZ = (ZI > ZJ) ? ZI - ZJ : ZJ - ZI;
				if (DX + DY + DZ <= 1) begin : g_adj
					assign reach[0][gi][gj] = occ[gi] & occ[gj];
				end else begin : g_far
					assign reach[0][gi][gj] = 1'b0;
				end
			end
		end

		// relation is symmetric, so row j doubles as column j
		for (gk = 0; gk < SQUARINGS; gk++) begin : g_sq
			for (gi = 0; gi < CELLS; gi++) begin : g_r
				for (gj = 0; gj < CELLS; gj++) begin : g_c
					assign reach[gk+1][gi][gj] = |(reach[gk][gi] & reach[gk][gj]);
				end
			end
		end

		// leader: occupied cell reaching no lower-numbered cell
		for (gi = 0; gi < CELLS; gi++) begin : g_lead
			localparam logic [CELLS-1:0] LOWER = CELLS'((64'd1 << gi) - 64'd1);
			assign lead[gi] = occ[gi] & ~|(reach[SQUARINGS][gi] & LOWER);
		end
	endgenerate

	assign lead_cnt = 5'($countones(lead));
	assign count    = lead_cnt[CNT_W-1:0];

endmodule

@@ rtl/topology_preserving_peel_check.sv @@
// ----------------------------------------------------------------------------
// Topology preserving peel check
// Simple-point decision for one voxel against its 3x3x3 neighbourhood.
// ----------------------------------------------------------------------------
// One word is taken on every clock (busy stays low). Each word is held in the
// input register, then passes through the component-count logic into the
// result register, from which it sits on the result port with done. done is a
// one-cycle strobe; the receiver must take the result in that cycle. The peel
// distance register accepts a write on any cycle (cfg_ready is always high).
module topology_preserving_peel_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tppc_pkg::in_word_t  item,
	output logic                done,
	output tppc_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import tppc_pkg::*;

	`include "topology_preserving_peel_check_macros.svh"

	logic [7:0]       peel_distance_q;
	logic             valid_s1;
	in_word_t         item_s1;
	logic             done_s2;
	result_t          result_s2;

	logic [CNT_W-1:0] cnt_before;
	logic [CNT_W-1:0] cnt_after;
	logic             skip;
	result_t          result_d;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peel_distance_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			peel_distance_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_s2 <= result_d;
		end
	end

	tppc_comp_count u_cnt_before (
		.occ   (item_s1.neighbour_occupancy | CENTRE_MASK),
		.count (cnt_before)
	);

	tppc_comp_count u_cnt_after (
		.occ   (item_s1.neighbour_occupancy & ~CENTRE_MASK),
		.count (cnt_after)
	);

	assign skip = (item_s1.centre_value <= peel_distance_q) ||
	              (item_s1.centre_value == BACKGROUND);

	always_comb begin
		result_d.remove_voxel      = 1'b0;
		result_d.new_value         = item_s1.centre_value;
		result_d.components_before = '0;
		if (!skip) begin
			result_d.components_before = cnt_before;
			if (cnt_before == cnt_after) begin
				result_d.remove_voxel = 1'b1;
				result_d.new_value    = BACKGROUND;
			end
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

	`TPPC_ASSERT_NXT(a_start_to_s1, clk, arst_n, start && !busy, valid_s1,
		"accepted word lost")
	`TPPC_ASSERT_NXT(a_s1_to_done, clk, arst_n, valid_s1, done,
		"stage 1 word gave no result")
	`TPPC_ASSERT_NXT(a_no_phantom, clk, arst_n, !valid_s1, !done,
		"result without a word")
	`TPPC_ASSERT_IMP(a_removed_bg, clk, arst_n, done && result.remove_voxel,
		result.new_value == BACKGROUND, "removed voxel not background")
	`TPPC_ASSERT_IMP(a_removed_cnt, clk, arst_n, done && result.remove_voxel,
		result.components_before != '0, "removed voxel with zero count")

endmodule

@@ verif/topology_preserving_peel_check_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peel check testbench
// Streams voxel neighbourhood words into the peel check with random start
// gaps and compares each done word against a flood-fill predictor. The peel
// distance register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module topology_preserving_peel_check_tb;
	import tppc_pkg::*;

	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_LIMIT  = 400;
	localparam int PHASE_WORDS  = 210;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	in_word_t   item      = '0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data  = 8'd0;
	logic       busy;
	logic       done;
	result_t    result;
	logic       cfg_ready;

	in_word_t   pending_words[$];
	result_t    expected_results[$];
	logic [7:0] peel_limit = 8'd0;
	bit         idle_on = 1'b1;
	bit         drive_next;
	int         gap_left = 0;
	int         error_count = 0;
	int         stall_cycles = 0;
	result_t    want;

	topology_preserving_peel_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// cells 6-adjacent to the set, plus the set; index is x*9 + y*3 + z
	function automatic logic [26:0] grow6(input logic [26:0] s);
		logic [26:0] r;
		int idx;
		r = s;
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				for (int z = 0; z < 3; z++) begin
					idx = x * 9 + y * 3 + z;
					if (s[idx]) begin
						if (x > 0) r[idx - 9] = 1'b1;
						if (x < 2) r[idx + 9] = 1'b1;
						if (y > 0) r[idx - 3] = 1'b1;
						if (y < 2) r[idx + 3] = 1'b1;
						if (z > 0) r[idx - 1] = 1'b1;
						if (z < 2) r[idx + 1] = 1'b1;
					end
				end
		return r;
	endfunction

	function automatic int count_regions(input logic [26:0] occ);
		logic [26:0] left, region, grown;
		int n;
		left = occ;
		n = 0;
		while (left != '0) begin
			region = left & (~left + 27'd1);
			grown = grow6(region) & occ;
			while (grown != region) begin
				region = grown;
				grown = grow6(region) & occ;
			end
			left &= ~region;
			n++;
		end
		return n;
	endfunction

	// cells whose offset from the centre is nonzero on exactly num_axes axes
	function automatic logic [26:0] shell_mask(input int num_axes);
		logic [26:0] m;
		m = '0;
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				for (int z = 0; z < 3; z++)
					if (int'(x != 1) + int'(y != 1) + int'(z != 1) == num_axes)
						m[x * 9 + y * 3 + z] = 1'b1;
		return m;
	endfunction

	function automatic result_t predict_peel(input in_word_t w);
		result_t r;
		int with_c, without_c;
		r.remove_voxel = 1'b0;
		r.new_value = w.centre_value;
		r.components_before = '0;
		if (w.centre_value > peel_limit && w.centre_value != BACKGROUND) begin
			with_c = count_regions(w.neighbour_occupancy | CENTRE_MASK);
			without_c = count_regions(w.neighbour_occupancy & ~CENTRE_MASK);
			r.components_before = with_c[CNT_W-1:0];
			if (with_c == without_c) begin
				r.remove_voxel = 1'b1;
				r.new_value = BACKGROUND;
			end
		end
		return r;
	endfunction

	function automatic in_word_t random_word(input int lim);
		in_word_t w;
		logic [31:0] a, b, c;
		a = $urandom();
		b = $urandom();
		c = $urandom();
		case ($urandom_range(0, 9))
			0: w.neighbour_occupancy = $urandom_range(0, 1) ? '1 : '0;
			1, 2, 3: w.neighbour_occupancy = a[26:0];
			4, 5: w.neighbour_occupancy = a[26:0] & b[26:0];
			6, 7: w.neighbour_occupancy = a[26:0] | b[26:0];
			8: w.neighbour_occupancy = a[26:0] & b[26:0] & c[26:0];
			default: w.neighbour_occupancy = shell_mask($urandom_range(1, 3)) | (a[26:0] & b[26:0]);
		endcase
		case ($urandom_range(0, 9))
			0: w.centre_value = BACKGROUND;
			1: w.centre_value = lim[7:0];
			2: w.centre_value = 8'($urandom_range(0, 255));
			default: w.centre_value = (lim >= 254) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(lim + 1, 254));
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_peel(input logic [7:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		peel_limit = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (start && !busy)
			expected_results.push_back(predict_peel(pending_words.pop_front()));
		if (gap_left > 0) begin
			gap_left--;
			drive_next = 1'b0;
		end else if (pending_words.size() == 0) begin
			drive_next = 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			gap_left = $urandom_range(0, 11);
			drive_next = 1'b0;
		end else begin
			drive_next = 1'b1;
		end
		start <= drive_next;
		if (drive_next)
			item <= pending_words[0];
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = expected_results.pop_front();
				if (result.remove_voxel !== want.remove_voxel)
					report_mismatch($sformatf("remove_voxel %0b, want %0b",
						result.remove_voxel, want.remove_voxel));
				if (result.new_value !== want.new_value)
					report_mismatch($sformatf("new_value %0d, want %0d",
						result.new_value, want.new_value));
				if (result.components_before !== want.components_before)
					report_mismatch($sformatf("components_before %0d, want %0d",
						result.components_before, want.components_before));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("topology_preserving_peel_check_tb: errors");
		$finish;
	end

	initial begin
		logic [7:0] peel_plan[8];
		logic [31:0] r;
		r = $urandom();
		peel_plan = '{8'd200, 8'd0, 8'd254, 8'd255, 8'd1, 8'd100, r[7:0], 8'd0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// peel distance is still at its reset value of 0
		pending_words.push_back('{BACKGROUND, '1});
		pending_words.push_back('{8'd0, '1});
		pending_words.push_back('{8'd1, '0});
		pending_words.push_back('{8'd1, CENTRE_MASK});
		pending_words.push_back('{8'd254, '1});
		pending_words.push_back('{8'd254, ~CENTRE_MASK});
		pending_words.push_back('{8'd200, shell_mask(1)});
		pending_words.push_back('{8'd200, 27'h0001000});
		pending_words.push_back('{8'd200, 27'h0400010});
		pending_words.push_back('{8'd100, shell_mask(3)});
		pending_words.push_back('{8'd100, shell_mask(2)});
		pending_words.push_back('{8'd100, shell_mask(1) | shell_mask(3)});
		pending_words.push_back('{8'd100, shell_mask(2) | shell_mask(3)});
		pending_words.push_back('{8'd100, shell_mask(1) | shell_mask(2)});
		pending_words.push_back('{8'd128, 27'h5555555});
		pending_words.push_back('{8'd127, 27'h2AAAAAA});
		pending_words.push_back('{8'd2, 27'h0000001});
		pending_words.push_back('{8'd2, 27'h4000000});
		pending_words.push_back('{8'd3, 27'h4000001 | CENTRE_MASK});

		foreach (peel_plan[p]) begin
			wait_drained();
			write_peel(peel_plan[p]);
			idle_on = (p != 7);
			for (int i = 0; i < PHASE_WORDS; i++)
				pending_words.push_back(random_word(int'(peel_plan[p])));
		end

		wait_drained();
		if (error_count == 0) begin
			$display("topology_preserving_peel_check_tb: clean");
		end else begin
			$display("topology_preserving_peel_check_tb: errors");
		end
		$finish;
	end

endmodule
